// File: hw/rtl/sdms_pkg.sv
// ----------------------------------------------------------------------------
// sdms_pkg: shared constants and helpers for the three-same-extra vector unit.
// Holds the group decode constants, the status codes and the lane functions
// that the top level and its computing part both use.
// ----------------------------------------------------------------------------
package sdms_pkg;

	localparam logic [31:0] GROUP_MASK  = 32'h9F20_8400;
	localparam logic [31:0] GROUP_MATCH = 32'h0E00_8400;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNDEF   = 2'd1;
	localparam logic [1:0] ST_NOGROUP = 2'd2;

	localparam logic [3:0] OPC_RDMLAH = 4'd0;
	localparam logic [3:0] OPC_RDMLSH = 4'd1;
	localparam logic [3:0] OPC_DOT    = 4'd2;
	localparam logic [3:0] OPC_USDOT  = 4'd3;
	localparam logic [3:0] OPC_MMLA   = 4'd4;
	localparam logic [3:0] OPC_USMMLA = 4'd5;

	localparam logic [1:0] SZ_H = 2'd1;
	localparam logic [1:0] SZ_S = 2'd2;

	// Operation selected by the decoder, carried into the datapath.
	typedef struct packed {
		logic       dot;
		logic       mmla;
		logic       rdm;
		logic       rdm_sub;
		logic       rdm_word;
		logic       ns;
		logic       ms;
		logic       scalar;
		logic       q;
		logic [1:0] status;
	} op_t;

	// Four-byte dot product of two 32-bit words, wrapping to 32 bits.
	function automatic logic [31:0] dot4(input logic [31:0] a, input logic [31:0] b,
		input logic ns, input logic ms);
		logic signed [8:0]  ea;
		logic signed [8:0]  eb;
		logic signed [17:0] p;
		logic [31:0]        s;
		s = '0;
		for (int k = 0; k < 4; k++) begin
			ea = {ns & a[8*k+7], a[8*k +: 8]};
			eb = {ms & b[8*k+7], b[8*k +: 8]};
			p  = ea * eb;
			s  = s + {{14{p[17]}}, p};
		end
		return s;
	endfunction

	// Saturating rounding doubling multiply-accumulate high half, 16 bits.
	function automatic logic [15:0] rdm16(input logic [15:0] acc, input logic [15:0] n,
		input logic [15:0] m, input logic sub);
		logic signed [31:0] prod;
		logic signed [32:0] x;
		logic signed [17:0] t;
		prod = $signed(n) * $signed(m);
		x    = sub ? -{prod[31], prod} : {prod[31], prod};
		x    = x + 33'sd16384;
		t    = {{2{acc[15]}}, acc} + x[32:15];
		if (t > 18'sd32767)       return 16'h7FFF;
		else if (t < -18'sd32768) return 16'h8000;
		else                      return t[15:0];
	endfunction

	// Same for 32-bit lanes.
	function automatic logic [31:0] rdm32(input logic [31:0] acc, input logic [31:0] n,
		input logic [31:0] m, input logic sub);
		logic signed [63:0] prod;
		logic signed [64:0] x;
		logic signed [33:0] t;
		prod = $signed(n) * $signed(m);
		x    = sub ? -{prod[63], prod} : {prod[63], prod};
		x    = x + 65'sd1073741824;
		t    = {{2{acc[31]}}, acc} + x[64:31];
		if (t > 34'sd2147483647)       return 32'h7FFF_FFFF;
		else if (t < -34'sd2147483648) return 32'h8000_0000;
		else                           return t[31:0];
	endfunction

endpackage

// File: hw/rtl/sdms_datapath.sv
// ----------------------------------------------------------------------------
// sdms_datapath: lane arithmetic of the three-same-extra unit.
// Combinational dot product, matrix multiply-accumulate and rounding
// doubling multiply-accumulate over registered operands.
// ----------------------------------------------------------------------------
module sdms_datapath (
	input  sdms_pkg::op_t op,
	input  logic [127:0]  n,
	input  logic [127:0]  m,
	input  logic [127:0]  acc,
	output logic [127:0]  dest
);

	logic [127:0] dot_r;
	logic [127:0] mm_r;
	logic [127:0] rdm_r;
	logic [127:0] res;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dot_r[32*i +: 32] = acc[32*i +: 32]
				+ sdms_pkg::dot4(n[32*i +: 32], m[32*i +: 32], op.ns, op.ms);
		end
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				mm_r[64*i+32*j +: 32] = acc[64*i+32*j +: 32]
					+ sdms_pkg::dot4(n[64*i +: 32], m[64*j +: 32], op.ns, op.ms)
					+ sdms_pkg::dot4(n[64*i+32 +: 32], m[64*j+32 +: 32], op.ns, op.ms);
			end
		end
		rdm_r = '0;
		if (op.rdm_word) begin
			for (int i = 0; i < 4; i++) begin
				if (!op.scalar || i == 0) begin
					rdm_r[32*i +: 32] = sdms_pkg::rdm32(acc[32*i +: 32], n[32*i +: 32],
						m[32*i +: 32], op.rdm_sub);
				end
			end
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (!op.scalar || i == 0) begin
					rdm_r[16*i +: 16] = sdms_pkg::rdm16(acc[16*i +: 16], n[16*i +: 16],
						m[16*i +: 16], op.rdm_sub);
				end
			end
		end
		if (op.status != sdms_pkg::ST_OK) res = '0;
		else if (op.dot)                  res = dot_r;
		else if (op.mmla)                 res = mm_r;
		else if (op.rdm)                  res = rdm_r;
		else                              res = '0;
		if (!op.q) res[127:64] = '0;
		dest = res;
	end

endmodule

// File: hw/rtl/simd_dot_mmla_sqrdmlah_unit.sv
// ----------------------------------------------------------------------------
// simd_dot_mmla_sqrdmlah_unit: 128-bit three-same-extra vector execution unit.
// Executes SDOT/UDOT/USDOT, SMMLA/UMMLA/USMMLA and SQRDMLAH/SQRDMLSH.
// ----------------------------------------------------------------------------
// Each request is decoded as it is accepted and its operands are captured in
// an input register; the lane arithmetic then runs combinationally into a
// result register, from which the result is presented, and a new request is
// taken every cycle unless the input is stalled. The throughput is one request
// per cycle while the output is not stalled. Input stall is raised only
// when both registers hold work and the output is stalled. Status 1 marks an
// undefined encoding inside the group (including MMLA with Q clear), status 2
// a word outside the group; in both cases the destination reads zero, and the
// upper half is zero whenever Q is clear.
// ----------------------------------------------------------------------------
module simd_dot_mmla_sqrdmlah_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] decode_word,
	input  logic        scalar_form,
	input  logic        q_bit,
	input  logic        u_bit,
	input  logic [63:0] src_n_low,
	input  logic [63:0] src_n_high,
	input  logic [63:0] src_m_low,
	input  logic [63:0] src_m_high,
	input  logic [63:0] acc_low,
	input  logic [63:0] acc_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] dest_low,
	output logic [63:0] dest_high,
	output logic [1:0]  status
);

	sdms_pkg::op_t op_dec;
	sdms_pkg::op_t op_s1;
	logic [127:0]  n_s1;
	logic [127:0]  m_s1;
	logic [127:0]  acc_s1;
	logic          valid_s1;
	logic [127:0]  dest_c;
	logic [127:0]  dest_s2;
	logic [1:0]    status_s2;
	logic          valid_s2;
	logic          adv_s2;
	logic          adv_s1;
	logic [3:0]    opc;
	logic [1:0]    size;
	logic          dot_ok;

	assign opc  = decode_word[14:11];
	assign size = decode_word[23:22];

	// Decode of the request word into the operation and its status.
	always_comb begin
		op_dec        = '0;
		op_dec.scalar = scalar_form;
		op_dec.q      = q_bit;
		op_dec.ns     = !u_bit && (opc == sdms_pkg::OPC_DOT || opc == sdms_pkg::OPC_MMLA);
		op_dec.ms     = !u_bit;
		dot_ok        = 1'b0;
		case (opc) inside
			sdms_pkg::OPC_DOT, sdms_pkg::OPC_MMLA:     dot_ok = 1'b1;
			sdms_pkg::OPC_USDOT, sdms_pkg::OPC_USMMLA: dot_ok = !u_bit;
			default:                                   dot_ok = 1'b0;
		endcase
		op_dec.rdm_sub  = (opc == sdms_pkg::OPC_RDMLSH);
		op_dec.rdm_word = (size == sdms_pkg::SZ_S);
		if ((decode_word & sdms_pkg::GROUP_MASK) != sdms_pkg::GROUP_MATCH) begin
			op_dec.status = sdms_pkg::ST_NOGROUP;
		end else if (!scalar_form && size == sdms_pkg::SZ_S && dot_ok) begin
			if (opc == sdms_pkg::OPC_DOT || opc == sdms_pkg::OPC_USDOT) begin
				op_dec.dot = 1'b1;
			end else if (!q_bit) begin
				op_dec.status = sdms_pkg::ST_UNDEF;
			end else begin
				op_dec.mmla = 1'b1;
			end
		end else if (u_bit && (opc == sdms_pkg::OPC_RDMLAH || opc == sdms_pkg::OPC_RDMLSH)
			&& (size == sdms_pkg::SZ_H || size == sdms_pkg::SZ_S)) begin
			op_dec.rdm = 1'b1;
		end else begin
			op_dec.status = sdms_pkg::ST_UNDEF;
		end
	end

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1  <= op_dec;
			n_s1   <= {src_n_high, src_n_low};
			m_s1   <= {src_m_high, src_m_low};
			acc_s1 <= {acc_high, acc_low};
		end
		if (adv_s2 && valid_s1) begin
			dest_s2   <= dest_c;
			status_s2 <= op_s1.status;
		end
	end

	sdms_datapath u_datapath (
		.op   (op_s1),
		.n    (n_s1),
		.m    (m_s1),
		.acc  (acc_s1),
		.dest (dest_c)
	);

	assign out_valid = valid_s2;
	assign dest_low  = dest_s2[63:0];
	assign dest_high = dest_s2[127:64];
	assign status    = status_s2;

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("status code out of range");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != sdms_pkg::ST_OK) |-> (dest_low == '0 && dest_high == '0))
		else $error("nonzero destination with error status");
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> valid_s2) else $error("result lost while stalled");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1) else $error("accepted request lost");

endmodule

// File: tb/sv/simd_dot_mmla_sqrdmlah_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd_dot_mmla_sqrdmlah_unit_test: self-checking bench for the vector unit.
// Directed requests cover decode edges, status codes and saturation corners,
// then random requests, mostly well-formed group encodings, are checked
// against a behavioral predictor with random idling on both channels.
// ----------------------------------------------------------------------------
module simd_dot_mmla_sqrdmlah_unit_test;

	localparam int RANDOM_REQUESTS = 1830;

	// One request as driven onto the input channel.
	typedef struct {
		logic [31:0] word;
		logic        scalar;
		logic        q;
		logic        u;
		logic [63:0] n_lo, n_hi, m_lo, m_hi, a_lo, a_hi;
	} request_t;

	// One destination as it leaves the unit.
	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [1:0]  st;
	} dest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] decode_word = '0;
	logic        scalar_form = 1'b0;
	logic        q_bit = 1'b0;
	logic        u_bit = 1'b0;
	logic [63:0] src_n_low = '0, src_n_high = '0, src_m_low = '0, src_m_high = '0;
	logic [63:0] acc_low = '0, acc_high = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [63:0] dest_low, dest_high;
	logic [1:0]  status;

	dest_t pending_dests[$];
	int    errors = 0;
	int    sent = 0;
	int    received = 0;
	int    n_dot = 0, n_mmla = 0, n_rdm = 0, n_undef = 0, n_nogroup = 0;
	bit    stimulus_done = 1'b0;

	simd_dot_mmla_sqrdmlah_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.decode_word(decode_word), .scalar_form(scalar_form),
		.q_bit(q_bit), .u_bit(u_bit),
		.src_n_low(src_n_low), .src_n_high(src_n_high),
		.src_m_low(src_m_low), .src_m_high(src_m_high),
		.acc_low(acc_low), .acc_high(acc_high),
		.out_valid(out_valid), .out_stall(out_stall),
		.dest_low(dest_low), .dest_high(dest_high), .status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Byte k of a 32-bit word, widened with or without its sign.
	function automatic longint byte_val(logic [31:0] w, int k, bit sgn);
		logic [7:0] b;
		b = w[8*k +: 8];
		return sgn ? longint'($signed(b)) : longint'(b);
	endfunction

	// Four-byte dot product, wrapping to 32 bits.
	function automatic logic [31:0] dot_word(logic [31:0] a, logic [31:0] b, bit sa, bit sb);
		longint acc;
		acc = 0;
		for (int k = 0; k < 4; k++)
			acc += byte_val(a, k, sa) * byte_val(b, k, sb);
		return acc[31:0];
	endfunction

	// Rounding doubling multiply-accumulate high half on an e-bit lane.
	// The doubled product plus half an LSB, shifted down by e, is added to
	// the accumulator and saturated to the signed lane range.
	function automatic logic [31:0] round_mac(logic [31:0] a, logic [31:0] n,
		logic [31:0] m, int e, bit sub);
		longint sa, sn, sm, prod, t, hi, lo;
		if (e == 16) begin
			sa = longint'($signed(a[15:0]));
			sn = longint'($signed(n[15:0]));
			sm = longint'($signed(m[15:0]));
		end else begin
			sa = longint'($signed(a));
			sn = longint'($signed(n));
			sm = longint'($signed(m));
		end
		prod = sn * sm;
		if (sub)
			prod = -prod;
		prod = prod + (longint'(1) << (e - 2));
		t = sa + (prod >>> (e - 1));
		hi = (longint'(1) << (e - 1)) - 1;
		lo = -hi - 1;
		if (t > hi)
			t = hi;
		if (t < lo)
			t = lo;
		return t[31:0];
	endfunction

	// Works out the destination and status for one request.
	function automatic dest_t execute_request(request_t r);
		dest_t       d;
		logic [127:0] vn, vm, va, vr;
		logic [31:0] lane;
		logic [3:0]  opc;
		logic [1:0]  size;
		bit          sn, sm, is_dot;
		int          e, lanes;
		vn = {r.n_hi, r.n_lo};
		vm = {r.m_hi, r.m_lo};
		va = {r.a_hi, r.a_lo};
		vr = va;
		opc = r.word[14:11];
		size = r.word[23:22];
		d.st = sdms_pkg::ST_OK;
		is_dot = 1'b0;
		sn = 1'b0;
		sm = 1'b0;
		if (opc == sdms_pkg::OPC_DOT || opc == sdms_pkg::OPC_MMLA) begin
			is_dot = 1'b1;
			sn = !r.u;
			sm = !r.u;
		end else if ((opc == sdms_pkg::OPC_USDOT || opc == sdms_pkg::OPC_USMMLA) && !r.u) begin
			is_dot = 1'b1;
			sm = 1'b1;
		end
		if ((r.word & sdms_pkg::GROUP_MASK) != sdms_pkg::GROUP_MATCH) begin
			d.st = sdms_pkg::ST_NOGROUP;
		end else if (!r.scalar && size == sdms_pkg::SZ_S && is_dot) begin
			if (opc <= sdms_pkg::OPC_USDOT) begin
				for (int i = 0; i < (r.q ? 4 : 2); i++)
					vr[32*i +: 32] = va[32*i +: 32]
						+ dot_word(vn[32*i +: 32], vm[32*i +: 32], sn, sm);
			end else if (!r.q) begin
				d.st = sdms_pkg::ST_UNDEF;
			end else begin
				// Row i of n (8 bytes) against row j of m, into lane 2i+j.
				for (int i = 0; i < 2; i++)
					for (int j = 0; j < 2; j++)
						vr[32*(2*i+j) +: 32] = va[32*(2*i+j) +: 32]
							+ dot_word(vn[64*i +: 32], vm[64*j +: 32], sn, sm)
							+ dot_word(vn[64*i+32 +: 32], vm[64*j+32 +: 32], sn, sm);
			end
		end else if (r.u && opc <= sdms_pkg::OPC_RDMLSH
			&& (size == sdms_pkg::SZ_H || size == sdms_pkg::SZ_S)) begin
			e = (size == sdms_pkg::SZ_H) ? 16 : 32;
			lanes = r.scalar ? 1 : ((r.q ? 128 : 64) / e);
			vr = '0;
			for (int i = 0; i < lanes; i++) begin
				if (e == 16) begin
					lane = round_mac(32'(va[16*i +: 16]), 32'(vn[16*i +: 16]),
						32'(vm[16*i +: 16]), 16, opc == sdms_pkg::OPC_RDMLSH);
					vr[16*i +: 16] = lane[15:0];
				end else begin
					vr[32*i +: 32] = round_mac(va[32*i +: 32], vn[32*i +: 32],
						vm[32*i +: 32], 32, opc == sdms_pkg::OPC_RDMLSH);
				end
			end
		end else begin
			d.st = sdms_pkg::ST_UNDEF;
		end
		if (d.st != sdms_pkg::ST_OK)
			vr = '0;
		if (!r.q)
			vr[127:64] = '0;
		d.lo = vr[63:0];
		d.hi = vr[127:64];
		return d;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Builds a group word for an opcode and size with random don't-care bits.
	function automatic logic [31:0] group_word(logic [3:0] opc, logic [1:0] size);
		logic [31:0] w;
		w = ($urandom & ~sdms_pkg::GROUP_MASK) | sdms_pkg::GROUP_MATCH;
		w[14:11] = opc;
		w[23:22] = size;
		return w;
	endfunction

	// Operand fill that favors saturation and sign edges.
	function automatic logic [63:0] edge64();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		2: return {4{16'h8000}};
		3: return {2{32'h8000_0000}};
		4: return {8{8'h80}};
		default: return rand64();
		endcase
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       kind;
		r.scalar = $urandom_range(0, 7) == 0;
		r.q = 1'($urandom_range(0, 1));
		r.u = 1'($urandom_range(0, 1));
		kind = $urandom_range(0, 99);
		if (kind < 85)
			r.word = group_word(4'($urandom_range(0, 5)), 2'($urandom_range(0, 3)));
		else if (kind < 92)
			r.word = group_word(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
		else
			r.word = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			r.n_lo = edge64(); r.n_hi = edge64();
			r.m_lo = edge64(); r.m_hi = edge64();
			r.a_lo = edge64(); r.a_hi = edge64();
		end else begin
			r.n_lo = rand64(); r.n_hi = rand64();
			r.m_lo = rand64(); r.m_hi = rand64();
			r.a_lo = rand64(); r.a_hi = rand64();
		end
		return r;
	endfunction

	// Offers one request at the falling edge and holds it until accepted.
	task automatic send_request(request_t r, int gap);
		dest_t d;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		decode_word <= r.word;
		scalar_form <= r.scalar;
		q_bit <= r.q;
		u_bit <= r.u;
		src_n_low <= r.n_lo; src_n_high <= r.n_hi;
		src_m_low <= r.m_lo; src_m_high <= r.m_hi;
		acc_low <= r.a_lo; acc_high <= r.a_hi;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		d = execute_request(r);
		pending_dests.push_back(d);
		case (d.st)
		sdms_pkg::ST_NOGROUP: n_nogroup++;
		sdms_pkg::ST_UNDEF: n_undef++;
		default: begin
			if (r.word[14:11] <= sdms_pkg::OPC_RDMLSH)
				n_rdm++;
			else if (r.word[14:11] >= sdms_pkg::OPC_MMLA)
				n_mmla++;
			else
				n_dot++;
		end
		endcase
		sent++;
		@(negedge clk);
	endtask

	// Directed table. Rows with check set carry a typed-in expectation that
	// must match the predictor; the rest rely on the predictor alone.
	typedef struct {
		request_t req;
		bit       check;
		dest_t    want;
	} directed_row_t;

	directed_row_t directed[$];

	task automatic add_row(logic [31:0] w, bit s, bit q, bit u, logic [63:0] n,
		logic [63:0] m, logic [63:0] a, bit check, logic [63:0] lo, logic [63:0] hi,
		logic [1:0] st);
		directed_row_t row;
		row.req = '{w, s, q, u, n, n, m, m, a, a};
		row.check = check;
		row.want = '{lo, hi, st};
		directed.push_back(row);
	endtask

	initial begin : stimulus
		logic [31:0] dot_s, mmla_s, rdm_h, rdm_s;
		dest_t       d;
		dot_s  = sdms_pkg::GROUP_MATCH | (32'(sdms_pkg::OPC_DOT) << 11)
			| (32'(sdms_pkg::SZ_S) << 22);
		mmla_s = sdms_pkg::GROUP_MATCH | (32'(sdms_pkg::OPC_MMLA) << 11)
			| (32'(sdms_pkg::SZ_S) << 22);
		rdm_h  = sdms_pkg::GROUP_MATCH | (32'(sdms_pkg::OPC_RDMLAH) << 11)
			| (32'(sdms_pkg::SZ_H) << 22);
		rdm_s  = sdms_pkg::GROUP_MATCH | (32'(sdms_pkg::OPC_RDMLAH) << 11)
			| (32'(sdms_pkg::SZ_S) << 22);
		// Outside the group, all-zero and all-one words.
		add_row(32'h0, 0, 1, 0, '1, '1, '1, 1, '0, '0, sdms_pkg::ST_NOGROUP);
		add_row(32'hFFFF_FFFF, 1, 1, 1, '1, '1, '1, 1, '0, '0, sdms_pkg::ST_NOGROUP);
		// Dot products: zero operands pass the accumulator through.
		add_row(dot_s, 0, 1, 0, '0, '0, '1, 1, '1, '1, sdms_pkg::ST_OK);
		add_row(dot_s, 0, 0, 1, '0, '0, '1, 1, '1, '0, sdms_pkg::ST_OK);
		add_row(dot_s, 0, 1, 0, '1, '1, '0, 1, {2{32'd4}}, {2{32'd4}}, sdms_pkg::ST_OK);
		add_row(dot_s, 0, 1, 1, '1, '1, '0, 0, '0, '0, sdms_pkg::ST_OK);
		add_row(dot_s | (32'(sdms_pkg::OPC_USDOT) << 11), 0, 1, 0, {8{8'h80}}, '1, '0,
			0, '0, '0, sdms_pkg::ST_OK);
		// USDOT with U set is undefined; dot in scalar form is undefined.
		add_row(dot_s | (32'(sdms_pkg::OPC_USDOT) << 11), 0, 1, 1, '1, '1, '1, 1, '0, '0,
			sdms_pkg::ST_UNDEF);
		add_row(dot_s, 1, 1, 0, '1, '1, '1, 1, '0, '0, sdms_pkg::ST_UNDEF);
		// Wrong size for a dot product.
		add_row(sdms_pkg::GROUP_MATCH | (32'(sdms_pkg::OPC_DOT) << 11), 0, 1, 0, '1, '1, '1,
			1, '0, '0, sdms_pkg::ST_UNDEF);
		// Matrix multiply-accumulate, both signs, and with Q clear.
		add_row(mmla_s, 0, 1, 0, {8{8'h80}}, {8{8'h80}}, '1, 0, '0, '0, sdms_pkg::ST_OK);
		add_row(mmla_s, 0, 1, 1, '1, '1, '1, 0, '0, '0, sdms_pkg::ST_OK);
		add_row(mmla_s | (32'(sdms_pkg::OPC_USMMLA) << 11), 0, 1, 0, '1, {8{8'h80}}, '0,
			0, '0, '0, sdms_pkg::ST_OK);
		add_row(mmla_s, 0, 0, 0, '1, '1, '1, 1, '0, '0, sdms_pkg::ST_UNDEF);
		add_row(mmla_s | (32'(sdms_pkg::OPC_USMMLA) << 11), 0, 1, 1, '1, '1, '1, 1, '0, '0,
			sdms_pkg::ST_UNDEF);
		// Rounding multiply: -1 times -1 saturates at the top of each lane, or at the bottom when subtracted.
		add_row(rdm_h, 0, 1, 1, {4{16'h8000}}, {4{16'h8000}}, {4{16'h7FFF}},
			1, {4{16'h7FFF}}, {4{16'h7FFF}}, sdms_pkg::ST_OK);
		add_row(rdm_s | (32'(sdms_pkg::OPC_RDMLSH) << 11), 0, 1, 1, {2{32'h8000_0000}},
			{2{32'h8000_0000}}, {2{32'h8000_0000}}, 1,
			{2{32'h8000_0000}}, {2{32'h8000_0000}}, sdms_pkg::ST_OK);
		// Scalar form keeps lane 0 only; Q clear drops the upper half.
		add_row(rdm_h, 1, 1, 1, '0, '0, '1, 1, 64'hFFFF, '0, sdms_pkg::ST_OK);
		add_row(rdm_s, 0, 0, 1, '0, '0, '1, 1, '1, '0, sdms_pkg::ST_OK);
		add_row(rdm_s, 0, 1, 1, '1, '1, 64'h1234_5678_9ABC_DEF0, 0, '0, '0, sdms_pkg::ST_OK);
		// Rounding multiply with U clear, or with byte or double size, and an unused opcode.
		add_row(rdm_h, 0, 1, 0, '1, '1, '1, 1, '0, '0, sdms_pkg::ST_UNDEF);
		add_row(sdms_pkg::GROUP_MATCH, 0, 1, 1, '1, '1, '1, 1, '0, '0, sdms_pkg::ST_UNDEF);
		add_row(sdms_pkg::GROUP_MATCH | (32'd3 << 22), 0, 1, 1, '1, '1, '1, 1, '0, '0,
			sdms_pkg::ST_UNDEF);
		add_row(sdms_pkg::GROUP_MATCH | (32'hF << 11), 0, 1, 1, '1, '1, '1, 1, '0, '0,
			sdms_pkg::ST_UNDEF);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].check) begin
				d = execute_request(directed[i].req);
				if (d != directed[i].want) begin
					$error("directed row %0d: predictor gives %h/%h/%0d, table %h/%h/%0d",
						i, d.lo, d.hi, d.st, directed[i].want.lo,
						directed[i].want.hi, directed[i].want.st);
					errors++;
				end
			end
			send_request(directed[i].req, $urandom_range(0, 2));
		end
		for (int i = 0; i < RANDOM_REQUESTS; i++)
			// Runs of back-to-back requests alternate with idle stretches.
			send_request(random_request(),
				(i % 200 < 60) ? 0 : $urandom_range(0, 19));
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Receiver: random stall per request, with one long hold-off early on
	// so the pipeline fills and pushes back on the sender.
	initial begin : receiver
		int wait_cycles;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			@(negedge clk);
			if (received == 40)
				wait_cycles = 60;
			else
				wait_cycles = ((received / 250) % 2 == 1) ? 0 : $urandom_range(0, 19);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
		end
	end

	// Checks every accepted destination against the oldest expectation.
	always @(posedge clk) begin
		dest_t want;
		if (arst_n && out_valid && !out_stall) begin
			received++;
			if (pending_dests.size() == 0) begin
				$error("destination with no request pending");
				errors++;
			end else begin
				want = pending_dests.pop_front();
				if (dest_low !== want.lo) begin
					$error("dest_low: expected %h, got %h", want.lo, dest_low);
					errors++;
				end
				if (dest_high !== want.hi) begin
					$error("dest_high: expected %h, got %h", want.hi, dest_high);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
			end
		end
	end

	initial begin : finish_run
		wait (stimulus_done);
		while (pending_dests.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d requests: %0d dot, %0d mmla, %0d rounding multiply,",
			sent, n_dot, n_mmla, n_rdm);
		$display("%0d undefined in group, %0d outside the group; %0d destinations checked.",
			n_undef, n_nogroup, received);
		if (errors == 0 && pending_dests.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Worst case is about 2000 requests.
	initial begin : watchdog
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/sdms_pkg.sv
hw/rtl/sdms_datapath.sv
hw/rtl/simd_dot_mmla_sqrdmlah_unit.sv
tb/sv/simd_dot_mmla_sqrdmlah_unit_test.sv
